>>> hw/rtl/kpc_pkg.sv
`timescale 1ns / 1ps

package kpc_pkg;

    // fixed field widths
    localparam int MASK_W      = 8;
    localparam int CNT_W       = 8;
    localparam int EV_KEY_W    = 3;
    localparam int OCC_OUT_W   = 5;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int KEYS_USE_W  = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    // parameter defaults
    localparam int KEYS_DEFAULT        = 8;
    localparam int QUEUE_DEPTH_DEFAULT = 16;

    // register reset values
    localparam logic [KEYS_USE_W-1:0] KEYS_IN_USE_RST = 4'd8;
    localparam logic [CNT_W-1:0]      SHORT_THR_RST   = 8'd3;
    localparam logic [CNT_W-1:0]      LONG_THR_RST    = 8'd50;
    localparam logic [CNT_W-1:0]      RELOAD_RST      = 8'd40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEYS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_THR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELOAD      = 2'd3;

    // item kinds and event kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_POP  = 1'b1;
    localparam logic EV_SHORT  = 1'b0;
    localparam logic EV_LONG   = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] short_thr;
        logic [CNT_W-1:0] long_thr;
        logic [CNT_W-1:0] reload;
    } kpc_cfg_t;

    typedef struct packed {
        logic                valid;
        logic [EV_KEY_W-1:0] key;
        logic                kind;
    } kpc_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } kpc_qstat_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DRAIN = 4'b0010,
        ST_READ  = 4'b0100,
        ST_DONE  = 4'b1000
    } kpc_state_t;

endpackage

>>> hw/rtl/kpc_ram.sv
`timescale 1ns / 1ps

module kpc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/kpc_lane.sv
`timescale 1ns / 1ps

module kpc_lane (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              enable,
    input  logic              held,
    input  kpc_pkg::kpc_cfg_t cfg,
    output logic              ev_valid,
    output logic              ev_kind
);
    import kpc_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] c_inc, c_upd;
    logic             hit_short, hit_long;

    always_comb begin
        c_inc     = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + CNT_W'(1);
        hit_short = (c_inc == cfg.short_thr);
        hit_long  = !hit_short && (c_inc == cfg.long_thr);
        if (!held) begin
            c_upd = '0;
        end else if (hit_long) begin
            c_upd = cfg.reload;
        end else begin
            c_upd = c_inc;
        end
        ev_valid = enable && held && (hit_short || hit_long);
        ev_kind  = hit_long ? EV_LONG : EV_SHORT;
        cnt_next = (step && enable) ? c_upd : cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> hw/rtl/kpc_merge.sv
`timescale 1ns / 1ps

module kpc_merge #(
    parameter int KEYS = kpc_pkg::KEYS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic [KEYS-1:0]    ev_valid,
    input  logic [KEYS-1:0]    ev_kind,
    input  logic               advance,
    output kpc_pkg::kpc_push_t push
);
    import kpc_pkg::*;

    logic [KEYS-1:0] pending_reg, pending_next;
    logic [KEYS-1:0] kinds_reg, kinds_next;

    // lowest pending key goes first, keeping key order
    always_comb begin
        push.valid = |pending_reg;
        push.key   = '0;
        push.kind  = EV_SHORT;
        for (int i = KEYS - 1; i >= 0; i--) begin
            if (pending_reg[i]) begin
                push.key  = EV_KEY_W'(i);
                push.kind = kinds_reg[i];
            end
        end
    end

    always_comb begin
        pending_next = pending_reg;
        kinds_next   = kinds_reg;
        if (load) begin
            pending_next = ev_valid;
            kinds_next   = ev_kind;
        end else if (advance) begin
            pending_next = pending_reg & (pending_reg - KEYS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
        kinds_reg <= kinds_next;
    end

endmodule

>>> hw/rtl/kpc_queue.sv
`timescale 1ns / 1ps

module kpc_queue #(
    parameter int QUEUE_DEPTH = kpc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  kpc_pkg::kpc_push_t               push,
    input  logic                             pop,
    output kpc_pkg::kpc_qstat_t              status,
    output logic [kpc_pkg::OCC_OUT_W-1:0]    occ_out,
    output logic [kpc_pkg::EV_KEY_W-1:0]     rd_key,
    output logic                             rd_kind
);
    import kpc_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int WORD_W = EV_KEY_W + 1;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             do_push, do_pop;
    logic [WORD_W-1:0] rd_word;
    logic [OCC_W+OCC_OUT_W-1:0] occ_wide;

    assign status.full  = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign status.empty = (occ_reg == '0);
    assign do_push = push.valid && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        occ_next    = occ_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            occ_next = occ_reg + OCC_W'(1);
        end else if (do_pop && !do_push) begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    kpc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (do_push),
        .wr_addr (wr_ptr_reg),
        .wr_data ({push.kind, push.key}),
        .rd_en   (do_pop),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_word)
    );

    assign rd_key   = rd_word[EV_KEY_W-1:0];
    assign rd_kind  = rd_word[EV_KEY_W];
    assign occ_wide = {{OCC_OUT_W{1'b0}}, occ_reg};
    assign occ_out  = occ_wide[OCC_OUT_W-1:0];

endmodule

>>> hw/rtl/key_press_classifier_fifo_unit.sv
`timescale 1ns / 1ps

// channel  | dir | ports                       | contents (low bit first)
// ---------+-----+-----------------------------+-------------------------------------------
// input    | in  | s_tvalid s_tready s_tdata   | tdata: pressed_mask[7:0]
//          |     | s_tuser                     | tuser: kind (0 scan tick, 1 pop)
// result   | out | m_tvalid m_tready m_tdata   | tdata: scan_had_event, dropped, event_valid,
//          |     |                             |   event_key[2:0], event_kind,
//          |     |                             |   events_waiting[4:0], zero pad to 16
// config   | in  | cfg_we cfg_index cfg_wdata  | 0 keys_in_use, 1 short, 2 long, 3 reload
//
// one item at a time. in a scan tick all key lanes update in the accept cycle, then the
// event queue, which has one write port, takes one event per cycle until the merge is
// empty, and the done state forms the result. a pop reads the queue ram in the accept
// cycle (the read is registered) and takes the word in the read state, or goes straight
// to done on an empty queue. the next item is taken while the result beat still waits
// in the output register; a stalled result holds the block only once its next result is
// ready. reset is synchronous, active low, with no clearing pass.

module key_press_classifier_fifo_unit #(
    parameter int KEYS        = kpc_pkg::KEYS_DEFAULT,
    parameter int QUEUE_DEPTH = kpc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kpc_pkg::S_TDATA_W-1:0]   s_tdata,   // pressed_mask
    input  logic [0:0]                      s_tuser,   // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kpc_pkg::M_TDATA_W-1:0]   m_tdata,   // had_event, dropped, event_valid,
                                                       // event_key, event_kind,
                                                       // events_waiting
    input  logic                            cfg_we,
    input  logic [kpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import kpc_pkg::*;

    kpc_state_t state_reg, state_next;

    logic [KEYS_USE_W-1:0] keys_in_use_reg;
    kpc_cfg_t              cfg_reg;

    logic                  accept, tick_acc, pop_acc;
    logic [KEYS-1:0]       lane_ev, lane_kind;
    kpc_push_t             push;
    kpc_qstat_t            qstat;
    logic [OCC_OUT_W-1:0]  occ_out;
    logic [EV_KEY_W-1:0]   rd_key;
    logic                  rd_kind;
    logic                  pop_go, out_free;

    logic                  had_reg, had_next;
    logic                  lost_reg, lost_next;
    logic                  evv_reg, evv_next;
    logic [EV_KEY_W-1:0]   key_reg, key_next;
    logic                  kind_reg, kind_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign tick_acc = accept && (s_tuser[0] == KIND_TICK);
    assign pop_acc  = accept && (s_tuser[0] == KIND_POP);
    assign pop_go   = pop_acc && !qstat.empty;
    assign out_free = !m_tvalid_reg || m_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keys_in_use_reg   <= KEYS_IN_USE_RST;
            cfg_reg.short_thr <= SHORT_THR_RST;
            cfg_reg.long_thr  <= LONG_THR_RST;
            cfg_reg.reload    <= RELOAD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KEYS_IN_USE: keys_in_use_reg   <= cfg_wdata[KEYS_USE_W-1:0];
                REG_SHORT_THR:   cfg_reg.short_thr <= cfg_wdata[CNT_W-1:0];
                REG_LONG_THR:    cfg_reg.long_thr  <= cfg_wdata[CNT_W-1:0];
                REG_RELOAD:      cfg_reg.reload    <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // one lane per key slot
    for (genvar g = 0; g < KEYS; g++) begin : g_lane
        logic lane_held;
        logic lane_en;

        if (g < MASK_W) begin : g_mask
            assign lane_held = s_tdata[g];
        end else begin : g_nomask
            assign lane_held = 1'b0;
        end

        assign lane_en = (32'(keys_in_use_reg) > 32'(g));

        kpc_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .step     (tick_acc),
            .enable   (lane_en),
            .held     (lane_held),
            .cfg      (cfg_reg),
            .ev_valid (lane_ev[g]),
            .ev_kind  (lane_kind[g])
        );
    end

    kpc_merge #(
        .KEYS (KEYS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (tick_acc),
        .ev_valid (lane_ev),
        .ev_kind  (lane_kind),
        .advance  (state_reg == ST_DRAIN),
        .push     (push)
    );

    kpc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop_go),
        .status  (qstat),
        .occ_out (occ_out),
        .rd_key  (rd_key),
        .rd_kind (rd_kind)
    );

    always_comb begin
        state_next    = state_reg;
        had_next      = had_reg;
        lost_next     = lost_reg;
        evv_next      = evv_reg;
        key_next      = key_reg;
        kind_next     = kind_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (tick_acc) begin
                    had_next   = |lane_ev;
                    lost_next  = 1'b0;
                    evv_next   = 1'b0;
                    key_next   = '0;
                    kind_next  = EV_SHORT;
                    state_next = ST_DRAIN;
                end else if (pop_acc) begin
                    had_next   = 1'b0;
                    lost_next  = 1'b0;
                    evv_next   = !qstat.empty;
                    key_next   = '0;
                    kind_next  = EV_SHORT;
                    state_next = qstat.empty ? ST_DONE : ST_READ;
                end
            end
            ST_DRAIN: begin
                if (push.valid) begin
                    if (qstat.full) begin
                        lost_next = 1'b1;
                    end
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_READ: begin
                key_next   = rd_key;
                kind_next  = rd_kind;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_TDATA_W - OCC_OUT_W - EV_KEY_W - 4){1'b0}},
                                     occ_out, kind_reg, key_reg, evv_reg, lost_reg, had_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        had_reg     <= had_next;
        lost_reg    <= lost_next;
        evv_reg     <= evv_next;
        key_reg     <= key_next;
        kind_reg    <= kind_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> dv/key_press_classifier_fifo_unit_tb.sv
`timescale 1ns / 1ps

module key_press_classifier_fifo_unit_tb;

    import kpc_pkg::*;

    localparam int N_KEYS     = KEYS_DEFAULT;
    localparam int FIFO_DEPTH = QUEUE_DEPTH_DEFAULT;

    typedef struct packed {
        logic       had_event;
        logic       dropped;
        logic       found;
        logic [2:0] key;
        logic       kind;
        logic [4:0] waiting;
    } key_result_t;

    typedef struct packed {
        logic [2:0] key;
        logic       kind;
    } queued_ev_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // pressed_mask[7:0]
    logic [0:0]            s_tuser;    // kind
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;    // had_event, dropped, event_valid, event_key[2:0],
                                       // event_kind, events_waiting[4:0], zero pad
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // own copy of the block state and settings
    logic [CNT_W-1:0]      hold_count [N_KEYS] = '{default: '0};
    queued_ev_t            queued_events [$];
    logic [KEYS_USE_W-1:0] model_keys   = KEYS_IN_USE_RST;
    logic [CNT_W-1:0]      model_short  = SHORT_THR_RST;
    logic [CNT_W-1:0]      model_long   = LONG_THR_RST;
    logic [CNT_W-1:0]      model_reload = RELOAD_RST;

    key_result_t           expected_results [$];
    int                    error_count  = 0;
    int                    beats_seen   = 0;
    bit                    no_idle      = 1'b0;
    int                    stall_left   = 0;

    key_press_classifier_fifo_unit #(
        .KEYS        (N_KEYS),
        .QUEUE_DEPTH (FIFO_DEPTH)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic key_result_t classify_item(input logic item_kind,
                                                  input logic [7:0] mask);
        key_result_t      res;
        queued_ev_t       ev;
        int               scan_n;
        logic [CNT_W-1:0] cnt;
        logic             fire;
        logic             fire_long;
        res = '0;
        if (item_kind == KIND_TICK) begin
            scan_n = (int'(model_keys) > N_KEYS) ? N_KEYS : int'(model_keys);
            for (int i = 0; i < scan_n; i++) begin
                cnt       = hold_count[i];
                fire      = 1'b0;
                fire_long = 1'b0;
                if (i < MASK_W && mask[i]) begin
                    if (cnt != CNT_MAX) cnt = cnt + CNT_W'(1);
                    // short wins when both thresholds match
                    if (cnt == model_short) begin
                        fire = 1'b1;
                    end else if (cnt == model_long) begin
                        fire      = 1'b1;
                        fire_long = 1'b1;
                        cnt       = model_reload;
                    end
                end else begin
                    cnt = '0;
                end
                hold_count[i] = cnt;
                if (fire) begin
                    res.had_event = 1'b1;
                    if (queued_events.size() >= FIFO_DEPTH) begin
                        res.dropped = 1'b1;
                    end else begin
                        ev.key  = 3'(i);
                        ev.kind = fire_long ? EV_LONG : EV_SHORT;
                        queued_events.push_back(ev);
                    end
                end
            end
        end else if (queued_events.size() != 0) begin
            ev        = queued_events.pop_front();
            res.found = 1'b1;
            res.key   = ev.key;
            res.kind  = ev.kind;
        end
        res.waiting = 5'(queued_events.size());
        return res;
    endfunction

    task automatic flag_mismatch(input string field, input int got, input int want);
        $display("mismatch at result beat %0d: %s got %0d want %0d",
                 beats_seen, field, got, want);
        error_count++;
    endtask

    // receiver side back-pressure
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            stall_left <= int'($urandom_range(1, 13));
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        key_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                flag_mismatch("beat with nothing expected", int'(m_tdata), 0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[0] !== want.had_event)
                    flag_mismatch("scan_had_event", int'(m_tdata[0]), int'(want.had_event));
                if (m_tdata[1] !== want.dropped)
                    flag_mismatch("dropped", int'(m_tdata[1]), int'(want.dropped));
                if (m_tdata[2] !== want.found)
                    flag_mismatch("event_valid", int'(m_tdata[2]), int'(want.found));
                if (m_tdata[5:3] !== want.key)
                    flag_mismatch("event_key", int'(m_tdata[5:3]), int'(want.key));
                if (m_tdata[6] !== want.kind)
                    flag_mismatch("event_kind", int'(m_tdata[6]), int'(want.kind));
                if (m_tdata[11:7] !== want.waiting)
                    flag_mismatch("events_waiting", int'(m_tdata[11:7]), int'(want.waiting));
                if (m_tdata[15:12] !== 4'd0)
                    flag_mismatch("pad bits", int'(m_tdata[15:12]), 0);
            end
            beats_seen++;
        end
    end

    // s_tvalid stays high after acceptance, and each call sets it again for its own item
    task automatic send_item(input logic item_kind, input logic [7:0] mask);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        expected_results.push_back(classify_item(item_kind, mask));
        s_tvalid <= 1'b1;
        s_tdata  <= mask;
        s_tuser  <= item_kind;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic load_settings(input logic [3:0] keys, input logic [7:0] short_thr,
                                 input logic [7:0] long_thr, input logic [7:0] reload);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= REG_KEYS_IN_USE;
        cfg_wdata <= {4'd0, keys};
        @(posedge aclk);
        cfg_index <= REG_SHORT_THR;
        cfg_wdata <= short_thr;
        @(posedge aclk);
        cfg_index <= REG_LONG_THR;
        cfg_wdata <= long_thr;
        @(posedge aclk);
        cfg_index <= REG_RELOAD;
        cfg_wdata <= reload;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        model_keys   = keys;
        model_short  = short_thr;
        model_long   = long_thr;
        model_reload = reload;
        @(posedge aclk);
    endtask

    task automatic load_random_settings();
        logic [3:0] keys;
        logic [7:0] short_thr;
        logic [7:0] long_thr;
        logic [7:0] reload;
        keys      = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(1, 8));
        short_thr = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 6));
        case ($urandom_range(0, 5))
            0: long_thr = short_thr;
            1: long_thr = 8'($urandom_range(0, 255));
            default: long_thr = short_thr + 8'($urandom_range(1, 12));
        endcase
        reload = (long_thr != 0) ? 8'($urandom_range(0, long_thr - 1))
                                 : 8'($urandom_range(0, 255));
        load_settings(keys, short_thr, long_thr, reload);
    endtask

    // held keys drift slowly so counts climb; churn is per mille per tick
    task automatic run_key_traffic(input int items, input int pop_pct, input int churn,
                                   input logic [7:0] start_mask);
        logic [7:0] held;
        held = start_mask;
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(0, 59) == 0) begin
                repeat (18) send_item(KIND_POP, 8'($urandom));
            end else if ($urandom_range(0, 99) < pop_pct) begin
                send_item(KIND_POP, 8'($urandom));
            end else begin
                if ($urandom_range(0, 999) < churn) begin
                    if ($urandom_range(0, 3) == 0) held = 8'($urandom);
                    else held[3'($urandom_range(0, 7))] ^= 1'b1;
                end
                send_item(KIND_TICK, held);
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_item(KIND_POP, 8'h00);        // empty queue
        repeat (3) send_item(KIND_TICK, 8'hFF);
        send_item(KIND_POP, 8'hFF);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_POP, 8'h5A);
        wait_drained();
    endtask

    task automatic test_queue_overflow();
        load_settings(4'd8, 8'd1, 8'd255, 8'd0);
        send_item(KIND_TICK, 8'hFF);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_TICK, 8'hFF);       // fills the queue exactly
        send_item(KIND_POP, 8'h00);
        send_item(KIND_POP, 8'h00);
        wait_drained();
    endtask

    task automatic test_corner_settings();
        // equal thresholds, key count beyond the slot count
        load_settings(4'd15, 8'd2, 8'd2, 8'd0);
        send_item(KIND_TICK, 8'h81);
        send_item(KIND_TICK, 8'h81);
        // nothing scanned, counters hold
        load_settings(4'd0, 8'd0, 8'd1, 8'd255);
        send_item(KIND_TICK, 8'hFF);
        // short threshold zero, long fires every tick with reload zero
        load_settings(4'd3, 8'd0, 8'd1, 8'd0);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_TICK, 8'h07);
        send_item(KIND_TICK, 8'h07);
        send_item(KIND_POP, 8'h00);
        wait_drained();
    endtask

    task automatic test_random_mix();
        for (int p = 0; p < 8; p++) begin
            load_random_settings();
            run_key_traffic(48, 35, 300, 8'($urandom));
        end
        wait_drained();
    endtask

    task automatic test_counter_saturation();
        // long threshold at the ceiling, reload at the ceiling keeps it firing
        load_settings(4'd15, 8'd0, 8'd255, 8'd255);
        run_key_traffic(380, 20, 8, 8'hFF);
        wait_drained();
    endtask

    task automatic test_steady_tail();
        no_idle = 1'b1;
        load_random_settings();
        run_key_traffic(80, 35, 300, 8'($urandom));
        wait_drained();
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_TICK;
        cfg_we    <= 1'b0;
        cfg_index <= REG_KEYS_IN_USE;
        cfg_wdata <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_queue_overflow();
        test_corner_settings();
        test_random_mix();
        test_counter_saturation();
        test_steady_tail();

        repeat (20) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
